/* hdl/lswc_pkg.sv */
// Package: widths, register map and shared types of the segment clipper.
package lswc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ADDR_BITS      = 4;

	// Register byte addresses
	localparam logic [ADDR_BITS-1:0] ADDR_LEFT   = 4'h0;
	localparam logic [ADDR_BITS-1:0] ADDR_BOTTOM = 4'h4;
	localparam logic [ADDR_BITS-1:0] ADDR_RIGHT  = 4'h8;
	localparam logic [ADDR_BITS-1:0] ADDR_TOP    = 4'hc;

	// Per-edge kind after the setup stage
	typedef enum logic [1:0] {
		EDGE_NONE  = 2'd0,
		EDGE_ENTER = 2'd1,
		EDGE_LEAVE = 2'd2,
		EDGE_KILL  = 2'd3
	} edge_kind_t;

endpackage

/* hdl/line_segment_window_clipper_top.sv */
// Top level: APB window registers, setup, four dividers, select, interpolation.
// Throughput: one segment per cycle; busy is always low.
// The depth is set by the divider pipeline, one quotient bit per stage.
// Reset: arst_n clears valid bits and loads the window with its reset values.
// done pulses for one cycle; the receiver cannot stall the pipeline.
module line_segment_window_clipper_top #(
	parameter int COORD_BITS = lswc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = lswc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lswc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [COORD_BITS-1:0]   start_x,
	input  logic signed [COORD_BITS-1:0]   start_y,
	input  logic signed [COORD_BITS-1:0]   end_x,
	input  logic signed [COORD_BITS-1:0]   end_y,
	output logic                           done,
	output logic                           visible,
	output logic signed [COORD_BITS-1:0]   clip_start_x,
	output logic signed [COORD_BITS-1:0]   clip_start_y,
	output logic signed [COORD_BITS-1:0]   clip_end_x,
	output logic signed [COORD_BITS-1:0]   clip_end_y
);
	import lswc_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int MB  = CB + 2;
	localparam int TB  = FRAC_BITS + 2;
	localparam int DL  = FRAC_BITS + 1;
	localparam int ONE = 1;

	logic [CB-1:0] left_q, bottom_q, right_q, top_q;

	// Window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			bottom_q <= '0;
			right_q  <= CB'(32767);
			top_q    <= CB'(32767);
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_LEFT:   left_q   <= pwdata[CB-1:0];
				ADDR_BOTTOM: bottom_q <= pwdata[CB-1:0];
				ADDR_RIGHT:  right_q  <= pwdata[CB-1:0];
				ADDR_TOP:    top_q    <= pwdata[CB-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_LEFT:   prdata = 32'(signed'(left_q));
			ADDR_BOTTOM: prdata = 32'(signed'(bottom_q));
			ADDR_RIGHT:  prdata = 32'(signed'(right_q));
			ADDR_TOP:    prdata = 32'(signed'(top_q));
			default:     prdata = '0;
		endcase
	end
	assign pready = 1'b1;
	assign busy   = 1'b0;

	// Stage 1: differences and edge distances
	logic                 v_s1;
	logic signed [CB:0]   x1_s1, y1_s1;
	logic signed [CB+1:0] dx_s1, dy_s1;
	logic signed [CB+1:0] q_s1 [4];
	logic signed [CB+1:0] p_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		logic signed [CB+1:0] dx, dy, x1, y1;
		x1 = (CB+2)'(start_x);
		y1 = (CB+2)'(start_y);
		dx = (CB+2)'(end_x) - x1;
		dy = (CB+2)'(end_y) - y1;
		x1_s1 <= (CB+1)'(start_x);
		y1_s1 <= (CB+1)'(start_y);
		dx_s1 <= dx;
		dy_s1 <= dy;
		p_s1[0] <= -dx;
		p_s1[1] <= dx;
		p_s1[2] <= -dy;
		p_s1[3] <= dy;
		q_s1[0] <= x1 - (CB+2)'(signed'(left_q));
		q_s1[1] <= (CB+2)'(signed'(right_q)) - x1;
		q_s1[2] <= y1 - (CB+2)'(signed'(bottom_q));
		q_s1[3] <= (CB+2)'(signed'(top_q)) - y1;
	end

	// Stage 2: classify edges, magnitudes into the dividers
	logic                 v_s2;
	edge_kind_t           kind_s2 [4];
	logic                 neg_s2  [4];
	logic [MB-1:0]        aq_s2   [4];
	logic [MB-1:0]        ap_s2   [4];
	logic signed [CB:0]   x1_s2, y1_s2;
	logic signed [CB+1:0] dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	for (genvar e = 0; e < 4; e++) begin : g_cls
		always_ff @(posedge clk) begin
			if (p_s1[e] == 0)
				kind_s2[e] <= q_s1[e] < 0 ? EDGE_KILL : EDGE_NONE;
			else
				kind_s2[e] <= p_s1[e] < 0 ? EDGE_ENTER : EDGE_LEAVE;
			neg_s2[e] <= (q_s1[e] != 0) && ((q_s1[e] < 0) != (p_s1[e] < 0));
			aq_s2[e]  <= q_s1[e] < 0 ? MB'(-q_s1[e]) : MB'(q_s1[e]);
			ap_s2[e]  <= p_s1[e] < 0 ? MB'(-p_s1[e]) : MB'(p_s1[e]);
		end
	end

	always_ff @(posedge clk) begin
		x1_s2 <= x1_s1;
		y1_s2 <= y1_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
	end

	// Dividers: FRAC_BITS + 1 stages
	logic [TB-1:0] quo [4];
	for (genvar e = 0; e < 4; e++) begin : g_div
		lswc_divider #(.MAG_BITS(MB), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk      (clk),
			.num      (aq_s2[e]),
			.den      (ap_s2[e] == '0 ? MB'(1) : ap_s2[e]),
			.quo      (quo[e])
		);
	end

	// Side delay line alongside the dividers
	logic                 v_d   [DL];
	edge_kind_t           k_d   [DL][4];
	logic                 n_d   [DL][4];
	logic signed [CB:0]   x1_d  [DL];
	logic signed [CB:0]   y1_d  [DL];
	logic signed [CB+1:0] dx_d  [DL];
	logic signed [CB+1:0] dy_d  [DL];

	for (genvar i = 0; i < DL; i++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_d[i] <= 1'b0;
			else         v_d[i] <= (i == 0) ? v_s2 : v_d[(i == 0) ? 0 : i-1];
		end
		always_ff @(posedge clk) begin
			if (i == 0) begin
				k_d[i] <= kind_s2;
				n_d[i] <= neg_s2;
				x1_d[i] <= x1_s2; y1_d[i] <= y1_s2;
				dx_d[i] <= dx_s2; dy_d[i] <= dy_s2;
			end else begin
				k_d[i] <= k_d[(i == 0) ? 0 : i-1];
				n_d[i] <= n_d[(i == 0) ? 0 : i-1];
				x1_d[i] <= x1_d[(i == 0) ? 0 : i-1];
				y1_d[i] <= y1_d[(i == 0) ? 0 : i-1];
				dx_d[i] <= dx_d[(i == 0) ? 0 : i-1];
				dy_d[i] <= dy_d[(i == 0) ? 0 : i-1];
			end
		end
	end

	// Stage 3: signed ratios, entering max and leaving min pairwise
	localparam int SB = TB + 1;
	logic signed [SB-1:0] r [4];
	for (genvar e = 0; e < 4; e++) begin : g_sgn
		assign r[e] = n_d[DL-1][e] ? -SB'(quo[e]) : SB'(quo[e]);
	end

	logic                 v_s3, kill_s3;
	logic signed [SB-1:0] ten_s3 [2];
	logic signed [SB-1:0] tex_s3 [2];
	logic signed [CB:0]   x1_s3, y1_s3;
	logic signed [CB+1:0] dx_s3, dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_d[DL-1];
	end

	always_ff @(posedge clk) begin
		logic signed [SB-1:0] a, b;
		logic                 kill;
		kill = 1'b0;
		for (int h = 0; h < 2; h++) begin
			a = '0;
			b = SB'(ONE) <<< FRAC_BITS;
			for (int k = 0; k < 2; k++) begin
				if (k_d[DL-1][2*h+k] == EDGE_KILL) kill = 1'b1;
				if (k_d[DL-1][2*h+k] == EDGE_ENTER && r[2*h+k] > a) a = r[2*h+k];
				if (k_d[DL-1][2*h+k] == EDGE_LEAVE && r[2*h+k] < b) b = r[2*h+k];
			end
			ten_s3[h] <= a;
			tex_s3[h] <= b;
		end
		kill_s3 <= kill;
		x1_s3 <= x1_d[DL-1]; y1_s3 <= y1_d[DL-1];
		dx_s3 <= dx_d[DL-1]; dy_s3 <= dy_d[DL-1];
	end

	// Stage 4: final min/max and decision
	logic                 v_s4, ok_s4;
	logic [FRAC_BITS:0]   ten_s4, tex_s4;
	logic signed [CB:0]   x1_s4, y1_s4;
	logic signed [CB+1:0] dx_s4, dy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		logic signed [SB-1:0] a, b;
		a = ten_s3[0] > ten_s3[1] ? ten_s3[0] : ten_s3[1];
		b = tex_s3[0] < tex_s3[1] ? tex_s3[0] : tex_s3[1];
		ok_s4  <= !kill_s3 && !(a > b);
		ten_s4 <= a[FRAC_BITS:0];
		tex_s4 <= b[FRAC_BITS:0];
		x1_s4 <= x1_s3; y1_s4 <= y1_s3;
		dx_s4 <= dx_s3; dy_s4 <= dy_s3;
	end

	// Stages 5-7: interpolation
	logic [CB-1:0] sx, sy, ex, ey;
	lswc_interp #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_sx (
		.clk(clk), .s(x1_s4), .d(dx_s4), .t(ten_s4), .res(sx));
	lswc_interp #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_sy (
		.clk(clk), .s(y1_s4), .d(dy_s4), .t(ten_s4), .res(sy));
	lswc_interp #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ex (
		.clk(clk), .s(x1_s4), .d(dx_s4), .t(tex_s4), .res(ex));
	lswc_interp #(.COORD_BITS(CB), .FRAC_BITS(FRAC_BITS)) u_ey (
		.clk(clk), .s(y1_s4), .d(dy_s4), .t(tex_s4), .res(ey));

	logic v_s5, v_s6, v_s7, ok_s5, ok_s6, ok_s7;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end
	always_ff @(posedge clk) begin
		ok_s5 <= ok_s4; ok_s6 <= ok_s5; ok_s7 <= ok_s6;
	end

	// Output word, zeroed when rejected
	assign done         = v_s7;
	assign visible      = ok_s7;
	assign clip_start_x = ok_s7 ? sx : '0;
	assign clip_start_y = ok_s7 ? sy : '0;
	assign clip_end_x   = ok_s7 ? ex : '0;
	assign clip_end_y   = ok_s7 ? ey : '0;
endmodule

/* hdl/lswc_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, saturating ratio.
module lswc_divider #(
	parameter int MAG_BITS  = 18,
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic [MAG_BITS-1:0]  num,
	input  logic [MAG_BITS-1:0]  den,
	output logic [FRAC_BITS+1:0] quo
);
	localparam int QB = FRAC_BITS + 2;
	localparam int RB = MAG_BITS + 1;

	logic [RB-1:0]       rem_s  [FRAC_BITS+1];
	logic [MAG_BITS-1:0] den_s  [FRAC_BITS+1];
	logic [QB-1:0]       quo_s  [FRAC_BITS+1];
	logic                sat_s  [FRAC_BITS+1];

	// Integer part: whole is 0, 1 or saturate
	always_ff @(posedge clk) begin
		logic [RB:0] twice;
		twice = {2'b0, den} << 1;
		den_s[0] <= den;
		sat_s[0] <= ({2'b0, num} >= twice);
		if ({1'b0, num} >= {1'b0, den}) begin
			rem_s[0] <= RB'(num - den);
			quo_s[0] <= QB'(1);
		end else begin
			rem_s[0] <= RB'(num);
			quo_s[0] <= '0;
		end
	end

	// One fraction bit per stage
	for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_bit
		logic [RB-1:0] sh;
		logic          ge;
		assign sh = {rem_s[i-1][RB-2:0], 1'b0};
		assign ge = sh >= {1'b0, den_s[i-1]};

		always_ff @(posedge clk) begin
			den_s[i] <= den_s[i-1];
			sat_s[i] <= sat_s[i-1];
			rem_s[i] <= ge ? RB'(sh - {1'b0, den_s[i-1]}) : sh;
			quo_s[i] <= {quo_s[i-1][QB-2:0], ge};
		end
	end

	assign quo = sat_s[FRAC_BITS] ? QB'((QB'(1) << FRAC_BITS) + QB'(1)) : quo_s[FRAC_BITS];
endmodule

/* hdl/lswc_interp.sv */
// Interpolator: start + t*d truncated toward zero, multiply then adjust.
module lswc_interp #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic signed [COORD_BITS:0]    s,
	input  logic signed [COORD_BITS+1:0]  d,
	input  logic        [FRAC_BITS:0]     t,
	output logic        [COORD_BITS-1:0]  res
);
	localparam int DB = COORD_BITS + 1;
	localparam int PB = DB + FRAC_BITS + 1;
	localparam int WB = COORD_BITS + 3;

	logic [DB-1:0]          ad;
	logic [PB-1:0]          prod_s1;
	logic                   neg_s1, pos_s1, full_s1;
	logic signed [WB-1:0]   s_s1, d_s1, base_s2;
	logic                   frac_s2, neg_s2, pos_s2;

	assign ad = d[COORD_BITS+1] ? DB'(-d) : DB'(d);

	// Stage 1: magnitude product
	always_ff @(posedge clk) begin
		prod_s1 <= PB'(ad) * PB'(t);
		neg_s1  <= d < 0;
		pos_s1  <= d > 0;
		full_s1 <= t[FRAC_BITS];
		s_s1    <= WB'(s);
		d_s1    <= WB'(d);
	end

	logic signed [WB-1:0] qm;
	assign qm = WB'(signed'({1'b0, prod_s1[PB-1:FRAC_BITS]}));

	// Stage 2: add to start
	always_ff @(posedge clk) begin
		if (full_s1) begin
			base_s2 <= s_s1 + d_s1;
			frac_s2 <= 1'b0;
		end else begin
			base_s2 <= neg_s1 ? s_s1 - qm : s_s1 + qm;
			frac_s2 <= prod_s1[FRAC_BITS-1:0] != '0;
		end
		neg_s2 <= neg_s1;
		pos_s2 <= pos_s1;
	end

	// Stage 3: truncate toward zero
	always_ff @(posedge clk) begin
		logic signed [WB-1:0] r;
		r = base_s2;
		if (frac_s2 && pos_s2 && base_s2 < 0) r = base_s2 + WB'(1);
		if (frac_s2 && !pos_s2 && base_s2 > 0) r = base_s2 - WB'(1);
		res <= r[COORD_BITS-1:0];
	end
endmodule

/* tb/tb.sv */
// Testbench for the segment clipper: directed and random segments checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import lswc_pkg::*;

	localparam int CW        = COORD_BITS_DEF;
	localparam int FW        = FRAC_BITS_DEF;
	localparam longint ONE_T = longint'(1) << FW;
	localparam int DRAIN     = FW + 16;
	localparam int STALL_MAX = 4000;

	typedef struct {
		logic                 visible;
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
	} clip_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 start = 1'b0;
	logic                 busy;
	logic signed [CW-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic                 done, visible;
	logic signed [CW-1:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;

	// window mirror
	logic signed [CW-1:0] w_left = 0, w_bottom = 0, w_right = 32767, w_top = 32767;

	clip_word_t clip_queue[$];
	int         errors = 0;
	int         n_sent = 0, n_seen = 0, n_visible = 0, n_windows = 0;
	int         idle_cycles = 0;
	int         burst_left = 0;

	line_segment_window_clipper_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.done(done), .visible(visible),
		.clip_start_x(clip_start_x), .clip_start_y(clip_start_y),
		.clip_end_x(clip_end_x), .clip_end_y(clip_end_y)
	);

	always #2 clk = ~clk;

	// edge ratio q/p in 2^-FW units, truncated toward zero, saturated at 2.0 and above
	function automatic longint edge_ratio(longint q, longint p);
		longint aq, ap, m;
		aq = q < 0 ? -q : q;
		ap = p < 0 ? -p : p;
		if (aq / ap >= 2)
			m = ONE_T + 1;
		else
			m = (aq << FW) / ap;
		if (aq != 0 && ((q < 0) != (p < 0)))
			return -m;
		return m;
	endfunction

	// point along the segment at t, truncated toward zero
	function automatic logic signed [CW-1:0] point_at(longint s, longint d, longint t);
		longint num;
		num = s * ONE_T + t * d;
		return CW'(num / ONE_T);
	endfunction

	function automatic clip_word_t clip_segment(logic signed [CW-1:0] x1, y1, x2, y2);
		clip_word_t w;
		longint     dx, dy, t, t_in, t_out;
		longint     p[4], q[4];
		logic       ok;
		dx = longint'(x2) - longint'(x1);
		dy = longint'(y2) - longint'(y1);
		p[0] = -dx; q[0] = longint'(x1) - longint'(w_left);
		p[1] = dx;  q[1] = longint'(w_right) - longint'(x1);
		p[2] = -dy; q[2] = longint'(y1) - longint'(w_bottom);
		p[3] = dy;  q[3] = longint'(w_top) - longint'(y1);
		t_in = 0;
		t_out = ONE_T;
		ok = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (p[i] == 0) begin
				if (q[i] < 0)
					ok = 1'b0;
			end else begin
				t = edge_ratio(q[i], p[i]);
				if (p[i] < 0 && t > t_in)
					t_in = t;
				if (p[i] > 0 && t < t_out)
					t_out = t;
			end
		end
		if (t_in > t_out)
			ok = 1'b0;
		w = '{1'b0, '0, '0, '0, '0};
		if (ok) begin
			w.visible = 1'b1;
			w.sx = point_at(x1, dx, t_in);
			w.sy = point_at(y1, dy, t_in);
			w.ex = point_at(x1, dx, t_out);
			w.ey = point_at(y1, dy, t_out);
		end
		return w;
	endfunction

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		if (start && !busy)
			idle_cycles <= 0;
		else if (done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (done) begin
			clip_word_t e;
			n_seen++;
			if (clip_queue.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = clip_queue.pop_front();
				if (visible !== e.visible) begin
					$error("visible: expected %0d, got %0d", e.visible, visible); errors++;
				end
				if (clip_start_x !== e.sx) begin
					$error("clip_start_x: expected %0d, got %0d", e.sx, clip_start_x); errors++;
				end
				if (clip_start_y !== e.sy) begin
					$error("clip_start_y: expected %0d, got %0d", e.sy, clip_start_y); errors++;
				end
				if (clip_end_x !== e.ex) begin
					$error("clip_end_x: expected %0d, got %0d", e.ex, clip_end_x); errors++;
				end
				if (clip_end_y !== e.ey) begin
					$error("clip_end_y: expected %0d, got %0d", e.ey, clip_end_y); errors++;
				end
				if (e.visible)
					n_visible++;
			end
		end
	end

	// watchdog on cycles with no progress
	always @(posedge clk) begin
		if (idle_cycles >= STALL_MAX) begin
			$display("line_segment_window_clipper_top: mismatch");
			$finish;
		end
	end

	// drop start for a random gap
	task automatic pause_sender(int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// send one segment word; hold start across a burst
	task automatic send_segment(logic signed [CW-1:0] x1, y1, x2, y2);
		@(negedge clk);
		start = 1'b1;
		start_x = x1; start_y = y1; end_x = x2; end_y = y2;
		@(posedge clk);
		while (busy) @(posedge clk);
		clip_queue.push_back(clip_segment(x1, y1, x2, y2));
		n_sent++;
	endtask

	// wait for every expected word plus the pipeline depth
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (clip_queue.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// APB write: setup then access; upper data bits are random junk
	task automatic write_reg(logic [ADDR_BITS-1:0] addr, logic signed [CW-1:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr;
		pwdata = {16'($urandom), val};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (addr)
			ADDR_LEFT:   w_left = val;
			ADDR_BOTTOM: w_bottom = val;
			ADDR_RIGHT:  w_right = val;
			ADDR_TOP:    w_top = val;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic set_window(int l, int b, int r, int t);
		drain();
		write_reg(ADDR_LEFT, CW'(l));
		write_reg(ADDR_BOTTOM, CW'(b));
		write_reg(ADDR_RIGHT, CW'(r));
		write_reg(ADDR_TOP, CW'(t));
		n_windows++;
	endtask

	function automatic logic signed [CW-1:0] clamp_coord(int v);
		if (v > 32767) return 16'sd32767;
		if (v < -32768) return -16'sd32768;
		return CW'(v);
	endfunction

	// coordinate near one of the window bounds, or anywhere
	function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] lo, hi);
		int base;
		case ($urandom_range(0, 4))
			0: base = lo;
			1: base = hi;
			2: base = (int'(lo) + int'(hi)) / 2;
			3: return CW'($urandom);
			default: base = int'(lo) + int'($urandom_range(0, 65535)) % 
				(int'(hi) - int'(lo) + 1 > 0 ? int'(hi) - int'(lo) + 1 : 1);
		endcase
		return clamp_coord(base + int'($urandom_range(0, 400)) - 200);
	endfunction

	task automatic test_directed_reset_window();
		send_segment(-100, 50, 100, 50);          // crosses left edge
		send_segment(10, 10, 20, 30);             // fully inside
		send_segment(-5, -5, -1, -1);             // fully outside
		send_segment(7, 7, 7, 7);                 // point inside
		send_segment(0, 0, 0, 0);                 // point on corner
		send_segment(-1, 5, -1, 5);               // point outside
		send_segment(-10, 20, -10, 90);           // parallel, outside
		send_segment(0, 20, 0, 90);               // parallel, on edge
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(32767, 32767, -32768, -32768);
		send_segment(-32768, 32767, 32767, -32768);
		send_segment(32767, -32768, 32767, 32767);
		send_segment(-1, 1, 1, -1);               // touches corner only
		send_segment(-3, 0, 0, 3);
	endtask

	task automatic test_small_window();
		set_window(-10, -10, 10, 10);
		send_segment(-11, 0, -9, 0);              // large ratio on the leaving edge
		send_segment(-32768, 1, -11, 1);          // parallel, outside
		send_segment(-20, -20, 20, 20);
		send_segment(20, -20, -20, 20);
		send_segment(-10, 10, 10, -10);
		send_segment(-21, 0, 0, 21);              // empty interval, misses corner
		send_segment(-15, 3, 17, -7);
		send_segment(5, 5, 5, 5);
	endtask

	task automatic test_extreme_windows();
		set_window(-32768, -32768, 32767, 32767);
		send_segment(-32768, -32768, 32767, 32767);
		send_segment(123, -4567, -32768, 32767);
		set_window(100, 100, -100, -100);         // inverted window
		send_segment(0, 0, 0, 0);
		send_segment(-200, -200, 200, 200);
		set_window(5, 5, 5, 5);                   // single point
		send_segment(5, 5, 5, 5);
		send_segment(0, 0, 10, 10);
		send_segment(0, 0, 10, 11);
	endtask

	task automatic test_random_segments(int total);
		int sent;
		sent = 0;
		while (sent < total) begin
			if (sent % 200 == 199)
				set_window($urandom_range(0, 60000) - 32768, $urandom_range(0, 60000) - 32768,
					$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
			if (sent % 200 == 99) begin
				int l, b;
				l = $urandom_range(0, 60000) - 32768;
				b = $urandom_range(0, 60000) - 32768;
				set_window(l, b, l + $urandom_range(0, 4000), b + $urandom_range(0, 4000));
			end
			if (sent == total / 2)
				drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 8));
			end
			burst_left--;
			if ($urandom_range(0, 9) == 0)
				send_segment(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
			else
				send_segment(near_coord(w_left, w_right), near_coord(w_bottom, w_top),
					near_coord(w_left, w_right), near_coord(w_bottom, w_top));
			sent++;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);
		test_directed_reset_window();
		test_small_window();
		test_extreme_windows();
		set_window(-1000, -800, 1200, 900);
		test_random_segments(1400);
		drain();
		$display("covered %0d segments over %0d window settings", n_sent, n_windows);
		$display("%0d results checked, %0d visible", n_seen, n_visible);
		if (errors == 0)
			$display("line_segment_window_clipper_top: match");
		else
			$display("line_segment_window_clipper_top: mismatch");
		$finish;
	end

endmodule

/* files.f */
hdl/lswc_pkg.sv
hdl/lswc_divider.sv
hdl/lswc_interp.sv
hdl/line_segment_window_clipper_top.sv
tb/tb.sv
